/* hdl/exp_adsr_pkg.sv */
// ----------------------------------------------------------------------------
// exp_adsr_pkg
// Shared widths, phase and command codes, register indexes and fixed-point
// constants for the exponential ADSR envelope.
// ----------------------------------------------------------------------------
package exp_adsr_pkg;

	localparam int unsigned LVL_W   = 25;  // Q1.23 level plus headroom
	localparam int unsigned CTL_W   = 24;  // Q1.23 control value
	localparam int unsigned COEF_W  = 24;  // Q0.24 coefficient
	localparam int unsigned OUT_W   = 24;  // Q1.23 output sample
	localparam int unsigned LOW_W   = 25;  // signed Q1.23 output floor
	localparam int unsigned PH_W    = 3;
	localparam int unsigned CMD_W   = 2;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned CFG_W   = 25;

	// shared multiplier operand and product widths
	localparam int unsigned MUL_A_W = 26;
	localparam int unsigned MUL_B_W = 25;
	localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

	// phase codes
	localparam logic [PH_W-1:0] PH_FINISHED = 3'd0;
	localparam logic [PH_W-1:0] PH_ATTACK   = 3'd1;
	localparam logic [PH_W-1:0] PH_DECAY    = 3'd2;
	localparam logic [PH_W-1:0] PH_SUSTAIN  = 3'd3;
	localparam logic [PH_W-1:0] PH_RELEASE  = 3'd4;

	// command codes
	localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd2;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_ATTACK_COEF   = 3'd0;
	localparam logic [IDX_W-1:0] REG_ATTACK_OFFSET = 3'd1;
	localparam logic [IDX_W-1:0] REG_DECAY_COEF    = 3'd2;
	localparam logic [IDX_W-1:0] REG_DECAY_OFFSET  = 3'd3;
	localparam logic [IDX_W-1:0] REG_SUSTAIN_LEVEL = 3'd4;
	localparam logic [IDX_W-1:0] REG_FADE_COEF     = 3'd5;
	localparam logic [IDX_W-1:0] REG_RELEASE_COEF  = 3'd6;
	localparam logic [IDX_W-1:0] REG_OUT_LOW       = 3'd7;

	// fixed-point constants
	localparam logic [OUT_W-1:0]  ONE_Q23     = 24'd8388608;
	localparam logic [LVL_W-1:0]  ATTACK_CAP  = 25'd8220836;  // 0.98
	localparam logic [LVL_W-1:0]  END_LEVEL   = 25'd8389;     // 0.001
	localparam logic [COEF_W-1:0] SMOOTH_KEEP = 24'd16609444; // 0.99
	localparam logic [COEF_W-1:0] SMOOTH_TAKE = 24'd167772;   // 0.01
	localparam logic [26:0]       OUT_HIGH    = 27'd8388608;

endpackage

/* hdl/exp_adsr_mul.sv */
// ----------------------------------------------------------------------------
// exp_adsr_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module exp_adsr_mul
	import exp_adsr_pkg::*;
(
	input  logic               clk,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic [MUL_P_W-1:0] prod
);

	logic [MUL_P_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

	assign prod = prod_q;

endmodule

/* hdl/exponential_adsr_envelope.sv */
// ----------------------------------------------------------------------------
// exponential_adsr_envelope
// Per-sample exponential ADSR envelope with smoothed control scaling.
// ----------------------------------------------------------------------------
// Each accepted request is one audio sample tick, optionally preceded by a
// note-on (restart attack from the current level) or note-off (go to release).
// The block updates the envelope level with a one-pole segment, smooths the
// control input, and returns one result: the scaled, clipped sample and the
// phase after the update. All arithmetic runs through one 26x25 multiplier
// with a registered product, stepped by a small sequencer through five
// products (ctl*0.99, target*0.01, coef*level, level*ctl, p*range). After
// the accepting edge in_ready stays low while the sequencer steps through
// S_CTL to S_FIN, and comes back together with the result, provided the
// previous result has been taken; a result still waiting at the output
// holds the last step until out_ready. Registers may be written only while
// the block is idle; writes are registered and have no read-back.
// ----------------------------------------------------------------------------
module exponential_adsr_envelope
	import exp_adsr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [CTL_W-1:0]  ctl_target,
	input  logic              sustain_enable,
	// result channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic [OUT_W-1:0]  sample,
	output logic [PH_W-1:0]   phase_now,
	// configuration
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,  // product of ctl*0.99 runs here every cycle
		S_CTL,   // hold ctl*0.99, multiply target*0.01
		S_SEG,   // new ctl, multiply coef*level
		S_LVL,   // segment result, phase step
		S_PMUL,  // multiply level*ctl
		S_PRND,  // round p
		S_QMUL,  // multiply p*|range|
		S_FIN    // offset, clip, load output
	} state_t;

	state_t state_q;

	// configuration registers
	logic [COEF_W-1:0]      attack_coef_q, attack_offset_q, decay_coef_q, decay_offset_q;
	logic [CTL_W-1:0]       sustain_level_q;
	logic [COEF_W-1:0]      fade_coef_q, release_coef_q;
	logic signed [LOW_W-1:0] out_low_q;

	// envelope state
	logic [PH_W-1:0]   phase_q;
	logic [LVL_W-1:0]  fb_q, shown_q;
	logic [CTL_W-1:0]  ctl_q;

	// per-request work registers
	logic [CTL_W-1:0]   target_q;
	logic               sus_en_q;
	logic [47:0]        acc_q;
	logic [MUL_A_W-1:0] p_q;

	// output register
	logic               out_valid_q;
	logic [OUT_W-1:0]   sample_q;
	logic [PH_W-1:0]    phase_now_q;

	// shared multiplier
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] prod;

	exp_adsr_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	assign in_ready = (state_q == S_IDLE);

	// ------------------------------------------------------------------
	// configuration writes
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_coef_q   <= '1;
			attack_offset_q <= '0;
			decay_coef_q    <= '1;
			decay_offset_q  <= '0;
			sustain_level_q <= ONE_Q23;
			fade_coef_q     <= '0;
			release_coef_q  <= '1;
			out_low_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ATTACK_COEF:   attack_coef_q   <= cfg_data[COEF_W-1:0];
				REG_ATTACK_OFFSET: attack_offset_q <= cfg_data[COEF_W-1:0];
				REG_DECAY_COEF:    decay_coef_q    <= cfg_data[COEF_W-1:0];
				REG_DECAY_OFFSET:  decay_offset_q  <= cfg_data[COEF_W-1:0];
				REG_SUSTAIN_LEVEL: sustain_level_q <= cfg_data[CTL_W-1:0];
				REG_FADE_COEF:     fade_coef_q     <= cfg_data[COEF_W-1:0];
				REG_RELEASE_COEF:  release_coef_q  <= cfg_data[COEF_W-1:0];
				REG_OUT_LOW:       out_low_q       <= signed'(cfg_data[LOW_W-1:0]);
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// segment coefficient and offset for the current phase
	// ------------------------------------------------------------------
	logic [COEF_W-1:0] seg_coef, seg_off;

	always_comb begin
		case (phase_q)
			PH_ATTACK: begin
				seg_coef = attack_coef_q;
				seg_off  = attack_offset_q;
			end
			PH_DECAY: begin
				seg_coef = decay_coef_q;
				seg_off  = decay_offset_q;
			end
			PH_SUSTAIN: begin
				seg_coef = fade_coef_q;
				seg_off  = '0;
			end
			PH_RELEASE: begin
				seg_coef = release_coef_q;
				seg_off  = '0;
			end
			default: begin
				seg_coef = '0;
				seg_off  = '0;
			end
		endcase
	end

	// output span: range = OUT_HIGH - out_low, kept as sign and magnitude
	logic [26:0]        range_full;
	logic               range_neg;
	logic [26:0]        range_mag;
	logic [MUL_B_W-1:0] range_abs;

	assign range_full = OUT_HIGH - 27'(out_low_q);  // sign-extends out_low_q
	assign range_neg  = range_full[26];
	assign range_mag  = range_neg ? (27'd0 - range_full) : range_full;
	assign range_abs  = range_mag[MUL_B_W-1:0];

	// operand selection for the shared multiplier
	always_comb begin
		case (state_q)
			S_IDLE: begin
				mul_a = MUL_A_W'(ctl_q);
				mul_b = MUL_B_W'(SMOOTH_KEEP);
			end
			S_CTL: begin
				mul_a = MUL_A_W'(target_q);
				mul_b = MUL_B_W'(SMOOTH_TAKE);
			end
			S_SEG: begin
				mul_a = MUL_A_W'(fb_q);
				mul_b = MUL_B_W'(seg_coef);
			end
			S_PMUL: begin
				mul_a = MUL_A_W'(shown_q);
				mul_b = MUL_B_W'(ctl_q);
			end
			S_QMUL, S_FIN: begin
				mul_a = p_q;
				mul_b = range_abs;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// datapath around the registered product
	// ------------------------------------------------------------------
	// control smoothing: (ctl*0.99 + target*0.01 + half) >> 24, saturated
	logic [48:0]      ctl_sum;
	logic [CTL_W-1:0] ctl_next;

	assign ctl_sum  = {1'b0, acc_q} + {7'd0, prod[41:0]} + 49'd8388608;
	assign ctl_next = ctl_sum[48] ? '1 : ctl_sum[47:24];

	// level segment: (coef*level + offset<<23 + half) >> 24, saturated
	logic [49:0]      seg_sum;
	logic [LVL_W:0]   seg_shift;
	logic [LVL_W-1:0] seg_val;

	assign seg_sum   = {1'b0, prod[48:0]} + ({26'd0, seg_off} << 23) + 50'd8388608;
	assign seg_shift = seg_sum[49:24];
	assign seg_val   = seg_shift[LVL_W] ? '1 : seg_shift[LVL_W-1:0];

	// p = (level*ctl + 2^22) >> 23
	logic [49:0] p_sum;
	assign p_sum = {1'b0, prod[48:0]} + 50'd4194304;

	// q = (p*|range| + 2^22) >> 23, sign restored, then offset and clip
	logic [MUL_P_W:0]   q_sum;
	logic [28:0]        q_mag;
	logic signed [30:0] q_signed;
	logic signed [30:0] out_sum;
	logic [OUT_W-1:0]   out_clip;

	assign q_sum    = {1'b0, prod} + (MUL_P_W+1)'(4194304);
	assign q_mag    = q_sum[51:23];
	assign q_signed = range_neg ? -signed'({2'b00, q_mag}) : signed'({2'b00, q_mag});
	assign out_sum  = 31'(out_low_q) + q_signed;

	always_comb begin
		if (out_sum < 31'sd0)
			out_clip = '0;
		else if (out_sum > 31'sd8388608)
			out_clip = ONE_Q23;
		else
			out_clip = out_sum[OUT_W-1:0];
	end

	// ------------------------------------------------------------------
	// sequencer, envelope state and output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_FINISHED;
			fb_q        <= '0;
			shown_q     <= '0;
			ctl_q       <= ONE_Q23;
			target_q    <= '0;
			sus_en_q    <= 1'b0;
			acc_q       <= '0;
			p_q         <= '0;
			out_valid_q <= 1'b0;
			sample_q    <= '0;
			phase_now_q <= PH_FINISHED;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						target_q <= ctl_target;
						sus_en_q <= sustain_enable;
						// note commands take effect before this tick's update
						if (cmd == CMD_NOTE_ON)
							phase_q <= PH_ATTACK;
						else if (cmd == CMD_NOTE_OFF)
							phase_q <= PH_RELEASE;
						state_q <= S_CTL;
					end
				end
				S_CTL: begin
					acc_q   <= prod[47:0];
					state_q <= S_SEG;
				end
				S_SEG: begin
					ctl_q   <= ctl_next;
					state_q <= S_LVL;
				end
				S_LVL: begin
					case (phase_q)
						PH_ATTACK: begin
							fb_q <= seg_val;
							if (seg_val >= ATTACK_CAP) begin
								// cap shows 0.98, feedback keeps the raw level
								shown_q <= ATTACK_CAP;
								phase_q <= PH_DECAY;
							end else begin
								shown_q <= seg_val;
							end
						end
						PH_DECAY: begin
							fb_q    <= seg_val;
							shown_q <= seg_val;
							if (seg_val <= LVL_W'(sustain_level_q))
								phase_q <= sus_en_q ? PH_SUSTAIN : PH_RELEASE;
						end
						PH_SUSTAIN, PH_RELEASE: begin
							if (seg_val <= END_LEVEL) begin
								phase_q <= PH_FINISHED;
								fb_q    <= '0;
								shown_q <= '0;
							end else begin
								fb_q    <= seg_val;
								shown_q <= seg_val;
							end
						end
						default: ;  // finished: levels hold
					endcase
					state_q <= S_PMUL;
				end
				S_PMUL: begin
					state_q <= S_PRND;
				end
				S_PRND: begin
					p_q     <= p_sum[48:23];
					state_q <= S_QMUL;
				end
				S_QMUL: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					// wait here while the previous result is still unclaimed
					if (!out_valid_q || out_ready) begin
						sample_q    <= out_clip;
						phase_now_q <= phase_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;
	assign phase_now = phase_now_q;

endmodule

/* hdl/exp_adsr_chk.sv */
// ----------------------------------------------------------------------------
// exp_adsr_chk
// Port-level checks for the exponential ADSR envelope, bound to the top level.
// ----------------------------------------------------------------------------
module exp_adsr_chk
	import exp_adsr_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [OUT_W-1:0] sample,
	input logic [PH_W-1:0]  phase_now
);

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(phase_now))
		else $error("result changed while stalled");

	// clipping keeps the sample within zero..one
	a_sample_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sample <= ONE_Q23)
		else $error("sample above one");

	// an accepted request makes the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after accepting a request");

	// a new result only appears out of a busy period
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while idle");

endmodule

bind exponential_adsr_envelope exp_adsr_chk u_exp_adsr_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.sample    (sample),
	.phase_now (phase_now)
);

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// exponential_adsr_envelope testbench
// Streams sample-tick requests with note-on and note-off into the envelope
// under random idling on both channels, predicts every result with a
// bit-exact fixed-point envelope of its own and checks sample and phase.
// ----------------------------------------------------------------------------
module testbench;
	import exp_adsr_pkg::*;

	// fixed-point constants of the envelope, kept apart from the package
	localparam longint UNITY      = 8388608;   // 1.0 in Q1.23
	localparam longint CAP_098    = 8220836;   // attack ceiling
	localparam longint FLOOR_0001 = 8389;      // end-of-note threshold
	localparam longint KEEP_099   = 16609444;  // control smoother, old part
	localparam longint TAKE_001   = 167772;    // control smoother, new part
	localparam longint LVL_SAT    = 33554431;  // 25-bit level ceiling
	localparam longint CTL_SAT    = 16777215;  // 24-bit control ceiling
	localparam logic [CTL_W-1:0] ONE_CTL = 24'd8388608;

	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;  // unused code, acts as a tick

	localparam int LATENCY      = 8;
	localparam int QUIET_LIMIT  = 1000;  // clocks with no traffic before giving up
	localparam int RANDOM_ITEMS = 1250;
	localparam int MAX_SHOWN    = 10;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [CTL_W-1:0] target;
		logic             sus_en;
	} tick_t;

	typedef struct packed {
		logic [OUT_W-1:0] sample;
		logic [PH_W-1:0]  phase;
	} result_t;

	// DUT pins; the inputs are all known from time zero
	logic              clk            = 1'b0;
	logic              arst_n         = 1'b0;
	logic              in_valid       = 1'b0;
	logic              in_ready;
	logic [CMD_W-1:0]  cmd            = '0;
	logic [CTL_W-1:0]  ctl_target     = '0;
	logic              sustain_enable = 1'b0;
	logic              out_valid;
	logic              out_ready      = 1'b0;
	logic [OUT_W-1:0]  sample;
	logic [PH_W-1:0]   phase_now;
	logic              cfg_we         = 1'b0;
	logic [IDX_W-1:0]  cfg_index      = '0;
	logic [CFG_W-1:0]  cfg_data       = '0;

	// request stream and expected samples
	tick_t   pending_ticks[$];
	result_t expected_results[$];
	tick_t   next_tick;
	tick_t   taken_tick;
	result_t want;
	int      queued_count  = 0;
	int      results_seen  = 0;
	int      mismatches    = 0;
	int      hold_off      = 0;
	int      stall_left    = 0;
	int      stall_now;
	int      quiet_cycles  = 0;
	logic    no_idle       = 1'b0;  // set for phases that run back to back

	// register image, matches the block after reset
	logic [COEF_W-1:0] atk_coef  = '1;
	logic [COEF_W-1:0] atk_off   = '0;
	logic [COEF_W-1:0] dec_coef  = '1;
	logic [COEF_W-1:0] dec_off   = '0;
	logic [COEF_W-1:0] sus_lvl   = 24'd8388608;
	logic [COEF_W-1:0] fade_k    = '0;
	logic [COEF_W-1:0] rel_coef  = '1;
	logic [LOW_W-1:0]  floor_lvl = '0;
	logic [CFG_W-1:0]  setting [8];

	// envelope state of the predictor
	logic [PH_W-1:0]   env_phase = PH_FINISHED;
	logic [LVL_W-1:0]  fb_lvl    = '0;  // level fed back, never capped
	logic [LVL_W-1:0]  shown_lvl = '0;  // level used for the output
	logic [CTL_W-1:0]  ctl_sm    = 24'd8388608;

	exponential_adsr_envelope i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cmd            (cmd),
		.ctl_target     (ctl_target),
		.sustain_enable (sustain_enable),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.sample         (sample),
		.phase_now      (phase_now),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// one-pole segment: (k*lvl + add/2 + half) >> 24, saturated at 25 bits
	function automatic logic [LVL_W-1:0] one_pole(input logic [COEF_W-1:0] k,
			input logic [LVL_W-1:0] lvl, input logic [COEF_W-1:0] add);
		longint kk, ll, aa, acc;
		kk = longint'(k);
		ll = longint'(lvl);
		aa = longint'(add);
		acc = (kk * ll + (aa << 23) + (longint'(1) << 23)) >> 24;
		if (acc > LVL_SAT)
			acc = LVL_SAT;
		return acc[LVL_W-1:0];
	endfunction

	// advance the envelope by one request and return the sample it produces
	function automatic result_t envelope_step(input tick_t t);
		longint lvl, ctl, tgt, acc, lo, rng, p, mag, q, s;
		result_t r;
		if (t.cmd == CMD_NOTE_ON)
			env_phase = PH_ATTACK;
		else if (t.cmd == CMD_NOTE_OFF)
			env_phase = PH_RELEASE;

		case (env_phase)
			PH_ATTACK: begin
				shown_lvl = one_pole(atk_coef, fb_lvl, atk_off);
				fb_lvl = shown_lvl;
				// only the shown level is clipped at the ceiling
				if (shown_lvl >= CAP_098) begin
					shown_lvl = LVL_W'(CAP_098);
					env_phase = PH_DECAY;
				end
			end
			PH_DECAY: begin
				shown_lvl = one_pole(dec_coef, fb_lvl, dec_off);
				fb_lvl = shown_lvl;
				if (shown_lvl <= {1'b0, sus_lvl})
					env_phase = t.sus_en ? PH_SUSTAIN : PH_RELEASE;
			end
			PH_SUSTAIN, PH_RELEASE: begin
				shown_lvl = one_pole((env_phase == PH_SUSTAIN) ? fade_k : rel_coef,
					fb_lvl, '0);
				fb_lvl = shown_lvl;
				if (shown_lvl <= FLOOR_0001) begin
					env_phase = PH_FINISHED;
					shown_lvl = '0;
					fb_lvl = '0;
				end
			end
			default: begin
			end
		endcase

		// control smoother, always runs
		ctl = longint'(ctl_sm);
		tgt = longint'(t.target);
		acc = (ctl * KEEP_099 + tgt * TAKE_001 + (longint'(1) << 23)) >> 24;
		if (acc > CTL_SAT)
			acc = CTL_SAT;
		ctl_sm = acc[CTL_W-1:0];

		// floor + level*ctl*range, magnitude rounded, then clipped to 0..1
		lo = longint'($signed(floor_lvl));
		rng = UNITY - lo;
		lvl = longint'(shown_lvl);
		ctl = longint'(ctl_sm);
		p = (lvl * ctl + (longint'(1) << 22)) >> 23;
		mag = (rng < 0) ? -rng : rng;
		q = (p * mag + (longint'(1) << 22)) >> 23;
		s = (rng < 0) ? lo - q : lo + q;
		if (s < 0)
			s = 0;
		else if (s > UNITY)
			s = UNITY;
		r.sample = s[OUT_W-1:0];
		r.phase = env_phase;
		return r;
	endfunction

	// driver: one request at a time, random hold-off after each
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			hold_off <= 0;
		end else begin
			if (in_valid && in_ready) begin
				taken_tick = {cmd, ctl_target, sustain_enable};
				expected_results.push_back(envelope_step(taken_tick));
			end
			if (in_valid && !in_ready) begin
				// request still waiting, keep it as is
			end else if (hold_off != 0) begin
				hold_off <= hold_off - 1;
				in_valid <= 1'b0;
			end else if (pending_ticks.size() != 0) begin
				next_tick = pending_ticks.pop_front();
				cmd <= next_tick.cmd;
				ctl_target <= next_tick.target;
				sustain_enable <= next_tick.sus_en;
				in_valid <= 1'b1;
				hold_off <= no_idle ? 0 : $urandom_range(0, 10);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: checks each sample, stalls for a random count of valid clocks
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			stall_now = stall_left;
			if (out_valid && out_ready) begin
				results_seen = results_seen + 1;
				if (expected_results.size() == 0) begin
					if (mismatches < MAX_SHOWN)
						$display("result %0d arrived with nothing expected: sample %0d phase %0d",
							results_seen, sample, phase_now);
					mismatches = mismatches + 1;
				end else begin
					want = expected_results.pop_front();
					if (sample !== want.sample) begin
						if (mismatches < MAX_SHOWN)
							$display("result %0d sample: expected %0d, got %0d",
								results_seen, want.sample, sample);
						mismatches = mismatches + 1;
					end
					if (phase_now !== want.phase) begin
						if (mismatches < MAX_SHOWN)
							$display("result %0d phase: expected %0d, got %0d",
								results_seen, want.phase, phase_now);
						mismatches = mismatches + 1;
					end
				end
				stall_now = no_idle ? 0 : $urandom_range(0, 10);
			end else if (out_valid && stall_now != 0) begin
				stall_now = stall_now - 1;
			end
			stall_left <= stall_now;
			out_ready <= (stall_now == 0);
		end
	end

	// watchdog: any handshake or register write counts as progress
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("exponential_adsr_envelope verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic queue_tick(input logic [CMD_W-1:0] c, input logic [CTL_W-1:0] tgt,
			input logic s);
		tick_t t;
		t.cmd = c;
		t.target = tgt;
		t.sus_en = s;
		pending_ticks.push_back(t);
		queued_count = queued_count + 1;
	endtask

	// block idle: nothing queued, nothing in flight, input side open;
	// looked at on the falling edge so the clocked blocks have settled
	task automatic wait_idle();
		while (pending_ticks.size() != 0 || in_valid || expected_results.size() != 0
				|| !in_ready)
			@(negedge clk);
	endtask

	// write all eight registers from setting[], one per clock
	task automatic program_setting();
		logic [IDX_W-1:0] idx;
		for (int r = 0; r < 8; r++) begin
			idx = IDX_W'(r);
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= setting[idx];
			case (idx)
				REG_ATTACK_COEF:   atk_coef = setting[idx][COEF_W-1:0];
				REG_ATTACK_OFFSET: atk_off = setting[idx][COEF_W-1:0];
				REG_DECAY_COEF:    dec_coef = setting[idx][COEF_W-1:0];
				REG_DECAY_OFFSET:  dec_off = setting[idx][COEF_W-1:0];
				REG_SUSTAIN_LEVEL: sus_lvl = setting[idx][COEF_W-1:0];
				REG_FADE_COEF:     fade_k = setting[idx][COEF_W-1:0];
				REG_RELEASE_COEF:  rel_coef = setting[idx][COEF_W-1:0];
				REG_OUT_LOW:       floor_lvl = setting[idx];
				default: begin
				end
			endcase
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// control target: mostly in range, with the edges and over-range values
	function automatic logic [CTL_W-1:0] draw_target();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return ONE_CTL;
			2: return '1;
			3: return CTL_W'($urandom);
			default: return CTL_W'($urandom_range(0, 8388608));
		endcase
	endfunction

	initial begin
		int     phase_no;
		int     phase_end;
		int     kind;
		longint dk, goal, doff;
		logic   sus;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset setting: attack cannot lift the level off zero
		queue_tick(CMD_TICK, '0, 1'b0);
		queue_tick(CMD_NOTE_OFF, ONE_CTL, 1'b0);   // release from finished
		queue_tick(CMD_SPARE, '1, 1'b1);           // unused code, over-range target
		queue_tick(CMD_NOTE_ON, '0, 1'b1);
		queue_tick(CMD_TICK, ONE_CTL, 1'b1);
		queue_tick(CMD_NOTE_OFF, 24'h555555, 1'b0);
		wait_idle();

		// attack 0.8/0.3, decay 0.5 toward 0.4, sustain at 0.5, floor -0.25
		setting[REG_ATTACK_COEF]   = 25'd13421773;
		setting[REG_ATTACK_OFFSET] = 25'd5033165;
		setting[REG_DECAY_COEF]    = 25'd8388608;
		setting[REG_DECAY_OFFSET]  = 25'd3355443;
		setting[REG_SUSTAIN_LEVEL] = 25'd4194304;
		setting[REG_FADE_COEF]     = 25'd15938355;
		setting[REG_RELEASE_COEF]  = 25'd11744051;
		setting[REG_OUT_LOW]       = -25'd2097152;
		program_setting();

		// full note: five attack steps hit the cap, three decay steps reach sustain
		queue_tick(CMD_NOTE_ON, ONE_CTL, 1'b1);
		repeat (4) queue_tick(CMD_TICK, '1, 1'b1);
		repeat (3) queue_tick(CMD_TICK, '0, 1'b1);
		repeat (2) queue_tick(CMD_TICK, ONE_CTL, 1'b1);
		queue_tick(CMD_NOTE_OFF, 24'hAAAAAA, 1'b0);
		repeat (2) queue_tick(CMD_TICK, ONE_CTL, 1'b0);
		queue_tick(CMD_NOTE_ON, 24'h123456, 1'b0);  // retrigger from release level
		queue_tick(CMD_TICK, '1, 1'b0);

		phase_no = 0;
		while (queued_count < 21 + RANDOM_ITEMS) begin
			wait_idle();
			kind = (phase_no < 2) ? 4 + phase_no : $urandom_range(0, 3);
			case (kind)
				4: begin
					// everything at the top; levels run into saturation
					setting[REG_ATTACK_COEF]   = '1;
					setting[REG_ATTACK_OFFSET] = 25'hFFFFFF;
					setting[REG_DECAY_COEF]    = '1;
					setting[REG_DECAY_OFFSET]  = 25'hFFFFFF;
					setting[REG_SUSTAIN_LEVEL] = 25'hFFFFFF;
					setting[REG_FADE_COEF]     = '1;
					setting[REG_RELEASE_COEF]  = '1;
					setting[REG_OUT_LOW]       = 25'd8388608;
				end
				5: begin
					// everything but the attack offset at the bottom, floor at -1.0 (range 2.0)
					setting[REG_ATTACK_COEF]   = '0;
					setting[REG_ATTACK_OFFSET] = 25'hFFFFFF;
					setting[REG_DECAY_COEF]    = '0;
					setting[REG_DECAY_OFFSET]  = '0;
					setting[REG_SUSTAIN_LEVEL] = '0;
					setting[REG_FADE_COEF]     = '0;
					setting[REG_RELEASE_COEF]  = '0;
					setting[REG_OUT_LOW]       = -25'd8388608;
				end
				2: begin
					for (int r = 0; r < 8; r++)
						case ($urandom_range(0, 2))
							0: setting[IDX_W'(r)] = '0;
							1: setting[IDX_W'(r)] = '1;
							default: setting[IDX_W'(r)] = CFG_W'($urandom);
						endcase
					setting[REG_OUT_LOW] = ($urandom_range(0, 1) == 1) ?
						25'd8388608 : -25'd8388608;
				end
				3: begin
					// raw 25-bit data, top bit must be dropped on 24-bit registers
					for (int r = 0; r < 8; r++)
						setting[IDX_W'(r)] = CFG_W'($urandom);
				end
				default: begin
					// playable envelope; decay aims at or a bit under the sustain level
					setting[REG_ATTACK_COEF]   = CFG_W'($urandom_range(0, 15000000));
					setting[REG_ATTACK_OFFSET] = CFG_W'($urandom_range(1000000, 16777215));
					setting[REG_DECAY_COEF]    = CFG_W'($urandom_range(8000000, 16700000));
					setting[REG_SUSTAIN_LEVEL] = CFG_W'($urandom_range(0, 8388608));
					dk = longint'(setting[REG_DECAY_COEF]);
					goal = longint'(setting[REG_SUSTAIN_LEVEL]);
					goal = goal * longint'($urandom_range(6, 8)) / 8;
					doff = ((longint'(16777216) - dk) * goal) >> 23;
					if (doff > CTL_SAT)
						doff = CTL_SAT;
					setting[REG_DECAY_OFFSET]  = doff[CFG_W-1:0];
					setting[REG_FADE_COEF]     = ($urandom_range(0, 3) == 0) ?
						25'd0 : CFG_W'($urandom_range(12000000, 16500000));
					setting[REG_RELEASE_COEF]  = CFG_W'($urandom_range(8000000, 16300000));
					setting[REG_OUT_LOW]       =
						CFG_W'($urandom_range(0, 16777216) - 8388608);
				end
			endcase
			program_setting();

			no_idle = ($urandom_range(0, 3) == 0);
			phase_end = queued_count + $urandom_range(40, 160);
			while (queued_count < phase_end) begin
				if ($urandom_range(0, 9) == 0) begin
					// stray request: any code, any payload
					queue_tick(CMD_W'($urandom_range(0, 3)), draw_target(),
						1'($urandom_range(0, 1)));
				end else begin
					sus = 1'($urandom_range(0, 1));
					queue_tick(CMD_NOTE_ON, draw_target(), sus);
					repeat ($urandom_range(1, 30))
						queue_tick(CMD_TICK, draw_target(),
							($urandom_range(0, 9) == 0) ? !sus : sus);
					if ($urandom_range(0, 4) != 0)
						queue_tick(CMD_NOTE_OFF, draw_target(), sus);
					repeat ($urandom_range(0, 30))
						queue_tick(CMD_TICK, draw_target(), sus);
				end
			end
			phase_no = phase_no + 1;
		end

		wait_idle();
		repeat (4 * LATENCY) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("exponential_adsr_envelope verification clean");
		else
			$display("exponential_adsr_envelope verification failed");
		$finish;
	end

endmodule
